FILE: rtl/assert_macros.svh
// assertion macros used by eight_bit_alu_with_flags_unit
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/alu8f_pkg.sv
// opcodes, constants and request/result types for the 8-bit flag alu
// no dependencies
package alu8f_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_ADC = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_SBC = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_XOR = 4'd5;
  localparam logic [3:0] OP_OR  = 4'd6;
  localparam logic [3:0] OP_CP  = 4'd7;
  localparam logic [3:0] OP_INC = 4'd8;
  localparam logic [3:0] OP_DEC = 4'd9;
  localparam logic [3:0] OP_DAA = 4'd10;
  localparam logic [3:0] OP_CPL = 4'd11;
  localparam logic [3:0] OP_SCF = 4'd12;
  localparam logic [3:0] OP_CCF = 4'd13;

  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] accumulator;
    logic [7:0] second_value;
    logic       zero_in;
    logic       subtract_in;
    logic       half_carry_in;
    logic       carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic       zero_out;
    logic       subtract_out;
    logic       half_carry_out;
    logic       carry_out;
  } alu_res_t;

endpackage

FILE: rtl/eight_bit_alu_with_flags_unit.sv
// 8-bit accumulator alu with z/n/h/c flags, request register, logic, result register
// depends on alu8f_pkg and assert_macros.svh
//
// One request is taken every clock: busy is never raised, so start may be held high
// for back-to-back operations. Each result passes through the request register and
// then the result register, and is shown for exactly one cycle with out_valid high;
// the receiver cannot stall it, so it must take every result in the cycle it is shown.
// The rate of one request per clock is set by the single combinational pass between
// the two registers.
`include "assert_macros.svh"

module eight_bit_alu_with_flags_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  alu8f_pkg::alu_req_t in_data,
  output logic               out_valid,
  output alu8f_pkg::alu_res_t out_data
);

  logic                in_valid_r;
  alu8f_pkg::alu_req_t in_req_r;
  logic                out_valid_r;
  alu8f_pkg::alu_res_t out_res_r;
  alu8f_pkg::alu_res_t out_res_nxt;

  logic       cin;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] daa_val;
  logic       daa_carry;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req_r <= in_data;
    end
    if (in_valid_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  // carry into the nine-bit sum and difference only for adc and sbc
  assign cin = (in_req_r.opcode == alu8f_pkg::OP_ADC || in_req_r.opcode == alu8f_pkg::OP_SBC)
               ? in_req_r.carry_in : 1'b0;

  assign add_sum  = {1'b0, in_req_r.accumulator} + {1'b0, in_req_r.second_value}
                    + {8'd0, cin};
  assign add_half = {1'b0, in_req_r.accumulator[3:0]} + {1'b0, in_req_r.second_value[3:0]}
                    + {4'd0, cin};
  assign sub_diff = {1'b0, in_req_r.accumulator} - {1'b0, in_req_r.second_value}
                    - {8'd0, cin};
  assign sub_half = {1'b0, in_req_r.accumulator[3:0]} - {1'b0, in_req_r.second_value[3:0]}
                    - {4'd0, cin};

  // decimal adjust after add or subtract
  always_comb begin
    daa_val   = in_req_r.accumulator;
    daa_carry = in_req_r.carry_in;
    if (!in_req_r.subtract_in) begin
      if (in_req_r.carry_in || in_req_r.accumulator > alu8f_pkg::DAA_HI_LIMIT) begin
        daa_val   = daa_val + alu8f_pkg::DAA_HI_ADJ;
        daa_carry = 1'b1;
      end
      if (in_req_r.half_carry_in || in_req_r.accumulator[3:0] > alu8f_pkg::DAA_LO_LIMIT) begin
        daa_val = daa_val + alu8f_pkg::DAA_LO_ADJ;
      end
    end else begin
      if (in_req_r.carry_in) begin
        daa_val = daa_val - alu8f_pkg::DAA_HI_ADJ;
      end
      if (in_req_r.half_carry_in) begin
        daa_val = daa_val - alu8f_pkg::DAA_LO_ADJ;
      end
    end
  end

  always_comb begin
    out_res_nxt.result_value   = in_req_r.accumulator;
    out_res_nxt.zero_out       = in_req_r.zero_in;
    out_res_nxt.subtract_out   = in_req_r.subtract_in;
    out_res_nxt.half_carry_out = in_req_r.half_carry_in;
    out_res_nxt.carry_out      = in_req_r.carry_in;
    unique case (in_req_r.opcode) inside
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
        out_res_nxt.result_value   = add_sum[7:0];
        out_res_nxt.zero_out       = (add_sum[7:0] == 8'd0);
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = add_half[4];
        out_res_nxt.carry_out      = add_sum[8];
      end
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC: begin
        out_res_nxt.result_value   = sub_diff[7:0];
        out_res_nxt.zero_out       = (sub_diff[7:0] == 8'd0);
        out_res_nxt.subtract_out   = 1'b1;
        out_res_nxt.half_carry_out = sub_half[4];
        out_res_nxt.carry_out      = sub_diff[8];
      end
      alu8f_pkg::OP_CP: begin
        out_res_nxt.zero_out       = (sub_diff[7:0] == 8'd0);
        out_res_nxt.subtract_out   = 1'b1;
        out_res_nxt.half_carry_out = sub_half[4];
        out_res_nxt.carry_out      = sub_diff[8];
      end
      alu8f_pkg::OP_AND: begin
        out_res_nxt.result_value   = in_req_r.accumulator & in_req_r.second_value;
        out_res_nxt.zero_out       = ((in_req_r.accumulator & in_req_r.second_value) == 8'd0);
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = 1'b1;
        out_res_nxt.carry_out      = 1'b0;
      end
      alu8f_pkg::OP_XOR: begin
        out_res_nxt.result_value   = in_req_r.accumulator ^ in_req_r.second_value;
        out_res_nxt.zero_out       = ((in_req_r.accumulator ^ in_req_r.second_value) == 8'd0);
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = 1'b0;
        out_res_nxt.carry_out      = 1'b0;
      end
      alu8f_pkg::OP_OR: begin
        out_res_nxt.result_value   = in_req_r.accumulator | in_req_r.second_value;
        out_res_nxt.zero_out       = ((in_req_r.accumulator | in_req_r.second_value) == 8'd0);
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = 1'b0;
        out_res_nxt.carry_out      = 1'b0;
      end
      alu8f_pkg::OP_INC: begin
        out_res_nxt.result_value   = in_req_r.second_value + 8'd1;
        out_res_nxt.zero_out       = (in_req_r.second_value == 8'hff);
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = (in_req_r.second_value[3:0] == 4'hf);
      end
      alu8f_pkg::OP_DEC: begin
        out_res_nxt.result_value   = in_req_r.second_value - 8'd1;
        out_res_nxt.zero_out       = (in_req_r.second_value == 8'd1);
        out_res_nxt.subtract_out   = 1'b1;
        out_res_nxt.half_carry_out = (in_req_r.second_value[3:0] == 4'h0);
      end
      alu8f_pkg::OP_DAA: begin
        out_res_nxt.result_value   = daa_val;
        out_res_nxt.zero_out       = (daa_val == 8'd0);
        out_res_nxt.half_carry_out = 1'b0;
        out_res_nxt.carry_out      = daa_carry;
      end
      alu8f_pkg::OP_CPL: begin
        out_res_nxt.result_value   = ~in_req_r.accumulator;
        out_res_nxt.subtract_out   = 1'b1;
        out_res_nxt.half_carry_out = 1'b1;
      end
      alu8f_pkg::OP_SCF: begin
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = 1'b0;
        out_res_nxt.carry_out      = 1'b1;
      end
      alu8f_pkg::OP_CCF: begin
        out_res_nxt.subtract_out   = 1'b0;
        out_res_nxt.half_carry_out = 1'b0;
        out_res_nxt.carry_out      = !in_req_r.carry_in;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

  `ASSERT_NEXT(a_req_to_stage, start && !busy, in_valid_r)
  `ASSERT_NEXT(a_stage_to_out, in_valid_r, out_valid_r)
  `ASSERT_SAME(a_cp_keeps_acc, out_valid_r && $past(in_req_r.opcode) == alu8f_pkg::OP_CP, out_res_r.result_value == $past(in_req_r.accumulator))

endmodule

FILE: bench/alu_flag_checker.sv
// result checker for the 8-bit flag alu: predicts every accepted request, compares results
// depends on alu8f_pkg
`timescale 1ns / 100ps

module alu_flag_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  alu8f_pkg::alu_req_t in_data,
  input  logic                out_valid,
  input  alu8f_pkg::alu_res_t out_data,
  output int                  fail_count,
  output int                  pending_count
);

  alu8f_pkg::alu_res_t expected_results[$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  function automatic alu8f_pkg::alu_res_t predict_alu(alu8f_pkg::alu_req_t rq);
    alu8f_pkg::alu_res_t rs;
    logic [8:0] sum;
    logic [4:0] nib;
    logic [7:0] diff;
    logic       cin;
    rs.result_value   = rq.accumulator;
    rs.zero_out       = rq.zero_in;
    rs.subtract_out   = rq.subtract_in;
    rs.half_carry_out = rq.half_carry_in;
    rs.carry_out      = rq.carry_in;
    case (rq.opcode) inside
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
        cin = (rq.opcode == alu8f_pkg::OP_ADC) ? rq.carry_in : 1'b0;
        sum = {1'b0, rq.accumulator} + {1'b0, rq.second_value} + {8'd0, cin};
        nib = {1'b0, rq.accumulator[3:0]} + {1'b0, rq.second_value[3:0]} + {4'd0, cin};
        rs.result_value   = sum[7:0];
        rs.zero_out       = (sum[7:0] == 8'h00);
        rs.subtract_out   = 1'b0;
        rs.half_carry_out = nib[4];
        rs.carry_out      = sum[8];
      end
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
        cin = (rq.opcode == alu8f_pkg::OP_SBC) ? rq.carry_in : 1'b0;
        diff = rq.accumulator - rq.second_value - {7'd0, cin};
        rs.half_carry_out = ({1'b0, rq.accumulator[3:0]}
                             < ({1'b0, rq.second_value[3:0]} + {4'd0, cin}));
        rs.carry_out      = ({1'b0, rq.accumulator} < ({1'b0, rq.second_value} + {8'd0, cin}));
        rs.result_value   = (rq.opcode == alu8f_pkg::OP_CP) ? rq.accumulator : diff;
        rs.zero_out       = (diff == 8'h00);
        rs.subtract_out   = 1'b1;
      end
      alu8f_pkg::OP_AND: begin
        rs.result_value   = rq.accumulator & rq.second_value;
        rs.zero_out       = (rs.result_value == 8'h00);
        rs.subtract_out   = 1'b0;
        rs.half_carry_out = 1'b1;
        rs.carry_out      = 1'b0;
      end
      alu8f_pkg::OP_XOR, alu8f_pkg::OP_OR: begin
        rs.result_value   = (rq.opcode == alu8f_pkg::OP_XOR)
                            ? (rq.accumulator ^ rq.second_value)
                            : (rq.accumulator | rq.second_value);
        rs.zero_out       = (rs.result_value == 8'h00);
        rs.subtract_out   = 1'b0;
        rs.half_carry_out = 1'b0;
        rs.carry_out      = 1'b0;
      end
      alu8f_pkg::OP_INC: begin
        rs.result_value   = rq.second_value + 8'd1;
        rs.zero_out       = (rs.result_value == 8'h00);
        rs.subtract_out   = 1'b0;
        rs.half_carry_out = (rq.second_value[3:0] == 4'hf);
      end
      alu8f_pkg::OP_DEC: begin
        rs.result_value   = rq.second_value - 8'd1;
        rs.zero_out       = (rs.result_value == 8'h00);
        rs.subtract_out   = 1'b1;
        rs.half_carry_out = (rq.second_value[3:0] == 4'h0);
      end
      alu8f_pkg::OP_DAA: begin
        diff = rq.accumulator;
        if (!rq.subtract_in) begin
          if (rq.carry_in || rq.accumulator > alu8f_pkg::DAA_HI_LIMIT) begin
            diff = diff + alu8f_pkg::DAA_HI_ADJ;
            rs.carry_out = 1'b1;
          end
          if (rq.half_carry_in || rq.accumulator[3:0] > alu8f_pkg::DAA_LO_LIMIT)
            diff = diff + alu8f_pkg::DAA_LO_ADJ;
        end else begin
          if (rq.carry_in) diff = diff - alu8f_pkg::DAA_HI_ADJ;
          if (rq.half_carry_in) diff = diff - alu8f_pkg::DAA_LO_ADJ;
        end
        rs.result_value   = diff;
        rs.zero_out       = (diff == 8'h00);
        rs.half_carry_out = 1'b0;
      end
      alu8f_pkg::OP_CPL: begin
        rs.result_value   = ~rq.accumulator;
        rs.subtract_out   = 1'b1;
        rs.half_carry_out = 1'b1;
      end
      alu8f_pkg::OP_SCF, alu8f_pkg::OP_CCF: begin
        rs.subtract_out   = 1'b0;
        rs.half_carry_out = 1'b0;
        rs.carry_out      = (rq.opcode == alu8f_pkg::OP_SCF) ? 1'b1 : ~rq.carry_in;
      end
      default: begin
      end
    endcase
    return rs;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(string field, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
  endtask

  always @(posedge clk) begin
    alu8f_pkg::alu_res_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with no request waiting", out_data));
        end else begin
          want = expected_results.pop_front();
          compare_field("result_value", int'(out_data.result_value),
                        int'(want.result_value));
          compare_field("zero_out", int'(out_data.zero_out), int'(want.zero_out));
          compare_field("subtract_out", int'(out_data.subtract_out),
                        int'(want.subtract_out));
          compare_field("half_carry_out", int'(out_data.half_carry_out),
                        int'(want.half_carry_out));
          compare_field("carry_out", int'(out_data.carry_out), int'(want.carry_out));
        end
      end
      if (start && !busy) expected_results.push_back(predict_alu(in_data));
    end
    pending_count <= expected_results.size();
  end

endmodule

FILE: bench/testbench.sv
// top of the 8-bit flag alu bench: clock, reset, directed and random requests, verdict
// depends on alu8f_pkg, eight_bit_alu_with_flags_unit and alu_flag_checker
`timescale 1ns / 100ps

module testbench;

  localparam logic [3:0] OP_SPARE_LO = 4'd14;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int RANDOM_COUNT = 1950;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  alu8f_pkg::alu_req_t in_data = '0;
  logic                out_valid;
  alu8f_pkg::alu_res_t out_data;
  int                  fail_count;
  int                  pending_count;

  always #10 clk = ~clk;

  eight_bit_alu_with_flags_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  alu_flag_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  function automatic alu8f_pkg::alu_req_t make_req(logic [3:0] op, logic [7:0] a,
                                                   logic [7:0] v, logic [3:0] znhc);
    alu8f_pkg::alu_req_t rq;
    rq.opcode        = op;
    rq.accumulator   = a;
    rq.second_value  = v;
    rq.zero_in       = znhc[3];
    rq.subtract_in   = znhc[2];
    rq.half_carry_in = znhc[1];
    rq.carry_in      = znhc[0];
    return rq;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[8] = '{8'h00, 8'hff, 8'h0f, 8'h10, 8'h99, 8'h9a, 8'h01, 8'h80};
    if ($urandom_range(0, 3) == 0) return corners[3'($urandom_range(0, 7))];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(alu8f_pkg::alu_req_t rq);
    start   <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    alu8f_pkg::alu_req_t directed[$];
    int gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edge values for every operation
    directed.push_back(make_req(alu8f_pkg::OP_ADD, 8'hff, 8'h01, 4'b0000));
    directed.push_back(make_req(alu8f_pkg::OP_ADD, 8'h00, 8'h00, 4'b1111));
    directed.push_back(make_req(alu8f_pkg::OP_ADC, 8'hff, 8'h00, 4'b0001));
    directed.push_back(make_req(alu8f_pkg::OP_ADC, 8'h0e, 8'h01, 4'b0001));
    directed.push_back(make_req(alu8f_pkg::OP_SUB, 8'h00, 8'h01, 4'b0000));
    directed.push_back(make_req(alu8f_pkg::OP_SUB, 8'hff, 8'hff, 4'b0101));
    directed.push_back(make_req(alu8f_pkg::OP_SBC, 8'h00, 8'hff, 4'b0001));
    directed.push_back(make_req(alu8f_pkg::OP_SBC, 8'h10, 8'h0f, 4'b1001));
    directed.push_back(make_req(alu8f_pkg::OP_AND, 8'hf0, 8'h0f, 4'b0001));
    directed.push_back(make_req(alu8f_pkg::OP_XOR, 8'hff, 8'hff, 4'b0111));
    directed.push_back(make_req(alu8f_pkg::OP_OR, 8'h00, 8'h00, 4'b0011));
    directed.push_back(make_req(alu8f_pkg::OP_CP, 8'h42, 8'h42, 4'b0000));
    directed.push_back(make_req(alu8f_pkg::OP_CP, 8'h00, 8'hff, 4'b1110));
    directed.push_back(make_req(alu8f_pkg::OP_INC, 8'h55, 8'hff, 4'b0001));
    directed.push_back(make_req(alu8f_pkg::OP_INC, 8'h55, 8'h0f, 4'b1110));
    directed.push_back(make_req(alu8f_pkg::OP_DEC, 8'haa, 8'h00, 4'b0000));
    directed.push_back(make_req(alu8f_pkg::OP_DEC, 8'haa, 8'h01, 4'b0001));
    directed.push_back(make_req(alu8f_pkg::OP_DAA, 8'h9a, 8'h00, 4'b0000));
    directed.push_back(make_req(alu8f_pkg::OP_DAA, 8'h00, 8'h00, 4'b0011));
    directed.push_back(make_req(alu8f_pkg::OP_DAA, 8'h66, 8'h00, 4'b0111));
    directed.push_back(make_req(alu8f_pkg::OP_CPL, 8'h00, 8'hff, 4'b1001));
    directed.push_back(make_req(alu8f_pkg::OP_SCF, 8'hff, 8'h00, 4'b1110));
    directed.push_back(make_req(alu8f_pkg::OP_CCF, 8'h80, 8'h00, 4'b0111));
    directed.push_back(make_req(OP_SPARE_LO, 8'h3c, 8'hc3, 4'b1010));
    directed.push_back(make_req(OP_SPARE_HI, 8'hc3, 8'h3c, 4'b0101));
    foreach (directed[i]) issue_request(directed[i]);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      issue_request(make_req(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                             4'($urandom_range(0, 15))));
      // every fourth block of 100 runs back to back
      gap = ((i / 100) % 4 == 3) ? 0 : pick_gap();
      if (i == RANDOM_COUNT / 2) drain_results();
      else idle_cycles(gap);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("eight_bit_alu_with_flags_unit test passed");
    end else begin
      $display("eight_bit_alu_with_flags_unit test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("eight_bit_alu_with_flags_unit test failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/alu8f_pkg.sv
rtl/eight_bit_alu_with_flags_unit.sv
bench/alu_flag_checker.sv
bench/testbench.sv
